### design/bfqd_pkg.sv
// ----------------------------------------------------------------------------
// bfqd_pkg
// Types, constants and saturation helpers for the body-frame drag pipeline.
// ----------------------------------------------------------------------------
package bfqd_pkg;

   // Register stages from input to the result register
   localparam int STAGES = 12;

   // round(0.01 * 2^32), applied as a product taken >> 32
   localparam logic signed [26:0] CENTI_K = 27'sd42949673;
   localparam logic signed [35:0] Q30_ONE = 36'sd1073741824;
   // Product magnitude limit, 2^60
   localparam logic [60:0] MAG_LIM = {1'b1, 60'd0};

   // Configuration register indexes
   localparam logic [2:0] CSR_FORCE_GAIN_X  = 3'd0;
   localparam logic [2:0] CSR_FORCE_GAIN_Y  = 3'd1;
   localparam logic [2:0] CSR_FORCE_GAIN_Z  = 3'd2;
   localparam logic [2:0] CSR_TORQUE_GAIN_X = 3'd3;
   localparam logic [2:0] CSR_TORQUE_GAIN_Y = 3'd4;
   localparam logic [2:0] CSR_TORQUE_GAIN_Z = 3'd5;

   typedef struct packed {
      logic signed [31:0] wind_x;
      logic signed [31:0] wind_y;
      logic signed [31:0] wind_z;
      logic signed [31:0] spin_x;
      logic signed [31:0] spin_y;
      logic signed [31:0] spin_z;
      logic signed [31:0] rot_w;
      logic signed [31:0] rot_x;
      logic signed [31:0] rot_y;
      logic signed [31:0] rot_z;
   } bfqd_req_type;

   typedef struct packed {
      logic signed [47:0] force_x;
      logic signed [47:0] force_y;
      logic signed [47:0] force_z;
      logic signed [47:0] torque_x;
      logic signed [47:0] torque_y;
      logic signed [47:0] torque_z;
   } bfqd_rsp_type;

   typedef struct packed {
      logic [STAGES-1:0] adv;
      logic [STAGES-1:0] vld;
   } bfqd_flow_type;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -36'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [79:0] v);
      logic signed [47:0] r;
      if (v > 80'sd140737488355327) begin
         r = 48'sh7fffffffffff;
      end else if (v < -80'sd140737488355328) begin
         r = 48'sh800000000000;
      end else begin
         r = v[47:0];
      end
      return r;
   endfunction

endpackage

### design/bfqd_flow.sv
// ----------------------------------------------------------------------------
// bfqd_flow
// Per-stage valid bits and advance enables; bubbles collapse under a stall.
// ----------------------------------------------------------------------------
module bfqd_flow
   import bfqd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          rsp_ready,
   output bfqd_flow_type flow_o
);

   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic [STAGES-1:0] adv;

   always_comb begin
      // a stage may advance when the result is taken or some stage at or after it is empty
      for (int k = 0; k < STAGES; k++) begin
         adv[k] = rsp_ready | ~(&(vld_ff | STAGES'((1 << k) - 1)));
      end
      vld_in[0] = adv[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      flow_o.adv = adv;
      flow_o.vld = vld_ff;
   end

endmodule

### design/bfqd_front.sv
// ----------------------------------------------------------------------------
// bfqd_front
// Quaternion to rotation matrix and wind scaling to m/s, three stages.
// ----------------------------------------------------------------------------
module bfqd_front
   import bfqd_pkg::*;
(
   input  logic               clock,
   input  logic [2:0]         adv,
   input  bfqd_req_type       req,
   output logic signed [31:0] mat_o  [3][3],
   output logic signed [31:0] wind_o [3],
   output logic signed [31:0] spin_o [3]
);

   // quaternion products: xx yy zz xy xz yz wx wy wz
   logic signed [63:0] qp_ff    [9];
   logic signed [63:0] qp_in    [9];
   logic signed [63:0] wp_ff    [3];
   logic signed [63:0] wp_in    [3];
   logic signed [33:0] qt_ff    [9];
   logic signed [33:0] qt_in    [9];
   logic signed [31:0] wind1_ff [3];
   logic signed [31:0] wind1_in [3];
   logic signed [31:0] wind2_ff [3];
   logic signed [31:0] spin0_ff [3];
   logic signed [31:0] spin1_ff [3];
   logic signed [31:0] spin2_ff [3];
   logic signed [31:0] mat_ff   [3][3];
   logic signed [31:0] mat_in   [3][3];
   logic signed [31:0] wsrc     [3];
   logic signed [35:0] qe       [9];
   logic signed [35:0] mraw     [3][3];

   always_comb begin
      wsrc[0] = req.wind_x;
      wsrc[1] = req.wind_y;
      wsrc[2] = req.wind_z;
      qp_in[0] = 64'(req.rot_x) * 64'(req.rot_x);
      qp_in[1] = 64'(req.rot_y) * 64'(req.rot_y);
      qp_in[2] = 64'(req.rot_z) * 64'(req.rot_z);
      qp_in[3] = 64'(req.rot_x) * 64'(req.rot_y);
      qp_in[4] = 64'(req.rot_x) * 64'(req.rot_z);
      qp_in[5] = 64'(req.rot_y) * 64'(req.rot_z);
      qp_in[6] = 64'(req.rot_w) * 64'(req.rot_x);
      qp_in[7] = 64'(req.rot_w) * 64'(req.rot_y);
      qp_in[8] = 64'(req.rot_w) * 64'(req.rot_z);
      for (int i = 0; i < 3; i++) begin
         wp_in[i] = 64'(wsrc[i]) * 64'(CENTI_K);
      end
   end

   // truncate toward zero
   always_comb begin
      for (int k = 0; k < 9; k++) begin
         qt_in[k] = 34'((qp_ff[k] + (qp_ff[k][63] ? 64'sd1073741823 : 64'sd0)) >>> 30);
      end
      for (int i = 0; i < 3; i++) begin
         wind1_in[i] = 32'((wp_ff[i] + (wp_ff[i][63] ? 64'sd4294967295 : 64'sd0)) >>> 32);
      end
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         qe[k] = 36'(qt_ff[k]);
      end
      mraw[0][0] = Q30_ONE - ((qe[1] + qe[2]) <<< 1);
      mraw[0][1] = (qe[3] - qe[8]) <<< 1;
      mraw[0][2] = (qe[4] + qe[7]) <<< 1;
      mraw[1][0] = (qe[3] + qe[8]) <<< 1;
      mraw[1][1] = Q30_ONE - ((qe[0] + qe[2]) <<< 1);
      mraw[1][2] = (qe[5] - qe[6]) <<< 1;
      mraw[2][0] = (qe[4] - qe[7]) <<< 1;
      mraw[2][1] = (qe[5] + qe[6]) <<< 1;
      mraw[2][2] = Q30_ONE - ((qe[0] + qe[1]) <<< 1);
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            mat_in[i][j] = sat32(mraw[i][j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         qp_ff       <= qp_in;
         wp_ff       <= wp_in;
         spin0_ff[0] <= req.spin_x;
         spin0_ff[1] <= req.spin_y;
         spin0_ff[2] <= req.spin_z;
      end
      if (adv[1]) begin
         qt_ff    <= qt_in;
         wind1_ff <= wind1_in;
         spin1_ff <= spin0_ff;
      end
      if (adv[2]) begin
         mat_ff   <= mat_in;
         wind2_ff <= wind1_ff;
         spin2_ff <= spin1_ff;
      end
   end

   assign mat_o  = mat_ff;
   assign wind_o = wind2_ff;
   assign spin_o = spin2_ff;

endmodule

### design/bfqd_to_body.sv
// ----------------------------------------------------------------------------
// bfqd_to_body
// Rotate wind and spin into the body frame with the transposed matrix.
// ----------------------------------------------------------------------------
module bfqd_to_body
   import bfqd_pkg::*;
(
   input  logic               clock,
   input  logic [1:0]         adv,
   input  logic signed [31:0] mat_i  [3][3],
   input  logic signed [31:0] wind_i [3],
   input  logic signed [31:0] spin_i [3],
   output logic signed [31:0] mat_o  [3][3],
   output logic signed [31:0] vel_o  [3],
   output logic signed [31:0] rate_o [3]
);

   logic signed [63:0] pw_ff   [3][3];
   logic signed [63:0] pw_in   [3][3];
   logic signed [63:0] ps_ff   [3][3];
   logic signed [63:0] ps_in   [3][3];
   logic signed [31:0] mat3_ff [3][3];
   logic signed [31:0] mat4_ff [3][3];
   logic signed [35:0] sw      [3];
   logic signed [35:0] ss      [3];
   logic signed [31:0] vel_ff  [3];
   logic signed [31:0] vel_in  [3];
   logic signed [31:0] rate_ff [3];
   logic signed [31:0] rate_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            pw_in[i][j] = 64'(mat_i[j][i]) * 64'(wind_i[j]);
            ps_in[i][j] = 64'(mat_i[j][i]) * 64'(spin_i[j]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sw[i] = '0;
         ss[i] = '0;
         for (int j = 0; j < 3; j++) begin
            sw[i] = sw[i] + 36'((pw_ff[i][j]
                  + (pw_ff[i][j][63] ? 64'sd1073741823 : 64'sd0)) >>> 30);
            ss[i] = ss[i] + 36'((ps_ff[i][j]
                  + (ps_ff[i][j][63] ? 64'sd1073741823 : 64'sd0)) >>> 30);
         end
         vel_in[i]  = sat32(sw[i]);
         rate_in[i] = sat32(ss[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         pw_ff   <= pw_in;
         ps_ff   <= ps_in;
         mat3_ff <= mat_i;
      end
      if (adv[1]) begin
         vel_ff  <= vel_in;
         rate_ff <= rate_in;
         mat4_ff <= mat3_ff;
      end
   end

   assign mat_o  = mat4_ff;
   assign vel_o  = vel_ff;
   assign rate_o = rate_ff;

endmodule

### design/bfqd_drag.sv
// ----------------------------------------------------------------------------
// bfqd_drag
// Per-axis v*|v| and -(w*|w|) times the gains, as sign and clamped magnitude.
// ----------------------------------------------------------------------------
module bfqd_drag
   import bfqd_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic [2:0]         adv,
   input  logic signed [31:0] mat_i   [3][3],
   input  logic signed [31:0] vel_i   [3],
   input  logic signed [31:0] rate_i  [3],
   input  logic [31:0]        fgain_i [3],
   input  logic [31:0]        tgain_i [3],
   output logic signed [31:0] mat_o   [3][3],
   output logic               f_neg_o [3],
   output logic [60:0]        f_mag_o [3],
   output logic               t_neg_o [3],
   output logic [60:0]        t_mag_o [3]
);

   localparam int SQ_W   = 64 - FRAC_BITS;
   localparam int HI_W   = SQ_W - 32;
   localparam int PH_W   = HI_W + 32;
   localparam int FULL_W = SQ_W + 32;

   logic [31:0]        vabs     [3];
   logic [31:0]        wabs     [3];
   logic [63:0]        vsq_ff   [3];
   logic [63:0]        vsq_in   [3];
   logic [63:0]        wsq_ff   [3];
   logic [63:0]        wsq_in   [3];
   logic               vneg5_ff [3];
   logic               wneg5_ff [3];
   logic               vneg6_ff [3];
   logic               wneg6_ff [3];
   logic [SQ_W-1:0]    vsh      [3];
   logic [SQ_W-1:0]    wsh      [3];
   logic [63:0]        flo_ff   [3];
   logic [63:0]        flo_in   [3];
   logic [PH_W-1:0]    fhi_ff   [3];
   logic [PH_W-1:0]    fhi_in   [3];
   logic [63:0]        tlo_ff   [3];
   logic [63:0]        tlo_in   [3];
   logic [PH_W-1:0]    thi_ff   [3];
   logic [PH_W-1:0]    thi_in   [3];
   logic [FULL_W-1:0]  ffull    [3];
   logic [FULL_W-1:0]  tfull    [3];
   logic [FULL_W-1:0]  fsc      [3];
   logic [FULL_W-1:0]  tsc      [3];
   logic [60:0]        fmag_ff  [3];
   logic [60:0]        fmag_in  [3];
   logic [60:0]        tmag_ff  [3];
   logic [60:0]        tmag_in  [3];
   logic               fneg_ff  [3];
   logic               tneg_ff  [3];
   logic signed [31:0] mat5_ff  [3][3];
   logic signed [31:0] mat6_ff  [3][3];
   logic signed [31:0] mat7_ff  [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vabs[i]   = vel_i[i][31]  ? 32'(-vel_i[i])  : 32'(vel_i[i]);
         wabs[i]   = rate_i[i][31] ? 32'(-rate_i[i]) : 32'(rate_i[i]);
         vsq_in[i] = 64'(vabs[i]) * 64'(vabs[i]);
         wsq_in[i] = 64'(wabs[i]) * 64'(wabs[i]);
      end
   end

   // split the square into low and high words against the 32-bit gain
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vsh[i]    = vsq_ff[i][63:FRAC_BITS];
         wsh[i]    = wsq_ff[i][63:FRAC_BITS];
         flo_in[i] = 64'(vsh[i][31:0]) * 64'(fgain_i[i]);
         fhi_in[i] = PH_W'(vsh[i][SQ_W-1:32]) * PH_W'(fgain_i[i]);
         tlo_in[i] = 64'(wsh[i][31:0]) * 64'(tgain_i[i]);
         thi_in[i] = PH_W'(wsh[i][SQ_W-1:32]) * PH_W'(tgain_i[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ffull[i]   = (FULL_W'(fhi_ff[i]) << 32) + FULL_W'(flo_ff[i]);
         tfull[i]   = (FULL_W'(thi_ff[i]) << 32) + FULL_W'(tlo_ff[i]);
         fsc[i]     = ffull[i] >> FRAC_BITS;
         tsc[i]     = tfull[i] >> FRAC_BITS;
         fmag_in[i] = (fsc[i] > FULL_W'(MAG_LIM)) ? MAG_LIM : 61'(fsc[i]);
         tmag_in[i] = (tsc[i] > FULL_W'(MAG_LIM)) ? MAG_LIM : 61'(tsc[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         vsq_ff   <= vsq_in;
         wsq_ff   <= wsq_in;
         mat5_ff  <= mat_i;
         for (int i = 0; i < 3; i++) begin
            vneg5_ff[i] <= vel_i[i][31];
            wneg5_ff[i] <= rate_i[i][31];
         end
      end
      if (adv[1]) begin
         flo_ff   <= flo_in;
         fhi_ff   <= fhi_in;
         tlo_ff   <= tlo_in;
         thi_ff   <= thi_in;
         vneg6_ff <= vneg5_ff;
         wneg6_ff <= wneg5_ff;
         mat6_ff  <= mat5_ff;
      end
      if (adv[2]) begin
         fmag_ff <= fmag_in;
         tmag_ff <= tmag_in;
         mat7_ff <= mat6_ff;
         for (int i = 0; i < 3; i++) begin
            fneg_ff[i] <= vneg6_ff[i];
            // torque opposes the spin
            tneg_ff[i] <= ~wneg6_ff[i];
         end
      end
   end

   assign mat_o   = mat7_ff;
   assign f_neg_o = fneg_ff;
   assign f_mag_o = fmag_ff;
   assign t_neg_o = tneg_ff;
   assign t_mag_o = tmag_ff;

endmodule

### design/bfqd_to_world.sv
// ----------------------------------------------------------------------------
// bfqd_to_world
// Rotate force and torque back to the world frame, scale and saturate.
// ----------------------------------------------------------------------------
module bfqd_to_world
   import bfqd_pkg::*;
(
   input  logic               clock,
   input  logic [3:0]         adv,
   input  logic signed [31:0] mat_i   [3][3],
   input  logic               f_neg_i [3],
   input  logic [60:0]        f_mag_i [3],
   input  logic               t_neg_i [3],
   input  logic [60:0]        t_mag_i [3],
   output bfqd_rsp_type       rsp_o
);

   logic [31:0]        mabs     [3][3];
   logic [63:0]        flo_ff   [3][3];
   logic [63:0]        flo_in   [3][3];
   logic [60:0]        fhi_ff   [3][3];
   logic [60:0]        fhi_in   [3][3];
   logic [63:0]        tlo_ff   [3][3];
   logic [63:0]        tlo_in   [3][3];
   logic [60:0]        thi_ff   [3][3];
   logic [60:0]        thi_in   [3][3];
   logic               fsg_ff   [3][3];
   logic               tsg_ff   [3][3];
   logic [92:0]        ffull    [3][3];
   logic [92:0]        tfull    [3][3];
   logic [92:0]        fsh      [3][3];
   logic [92:0]        tsh      [3][3];
   logic [60:0]        fm       [3][3];
   logic [60:0]        tm       [3][3];
   logic signed [61:0] fterm_ff [3][3];
   logic signed [61:0] fterm_in [3][3];
   logic signed [61:0] tterm_ff [3][3];
   logic signed [61:0] tterm_in [3][3];
   logic signed [63:0] wf_ff    [3];
   logic signed [63:0] wf_in    [3];
   logic signed [63:0] wt_ff    [3];
   logic signed [63:0] wt_in    [3];
   logic signed [79:0] fprod    [3];
   logic signed [79:0] tprod    [3];
   bfqd_rsp_type       rsp_ff;
   bfqd_rsp_type       rsp_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            mabs[i][j]   = mat_i[i][j][31] ? 32'(-mat_i[i][j]) : 32'(mat_i[i][j]);
            flo_in[i][j] = 64'(mabs[i][j]) * 64'(f_mag_i[j][31:0]);
            fhi_in[i][j] = 61'(mabs[i][j]) * 61'(f_mag_i[j][60:32]);
            tlo_in[i][j] = 64'(mabs[i][j]) * 64'(t_mag_i[j][31:0]);
            thi_in[i][j] = 61'(mabs[i][j]) * 61'(t_mag_i[j][60:32]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            ffull[i][j] = (93'(fhi_ff[i][j]) << 32) + 93'(flo_ff[i][j]);
            tfull[i][j] = (93'(thi_ff[i][j]) << 32) + 93'(tlo_ff[i][j]);
            fsh[i][j]   = ffull[i][j] >> 30;
            tsh[i][j]   = tfull[i][j] >> 30;
            fm[i][j]    = (fsh[i][j] > 93'(MAG_LIM)) ? MAG_LIM : 61'(fsh[i][j]);
            tm[i][j]    = (tsh[i][j] > 93'(MAG_LIM)) ? MAG_LIM : 61'(tsh[i][j]);
            fterm_in[i][j] = fsg_ff[i][j] ? -$signed({1'b0, fm[i][j]})
                                          : $signed({1'b0, fm[i][j]});
            tterm_in[i][j] = tsg_ff[i][j] ? -$signed({1'b0, tm[i][j]})
                                          : $signed({1'b0, tm[i][j]});
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         wf_in[i] = 64'(fterm_ff[i][0]) + 64'(fterm_ff[i][1]) + 64'(fterm_ff[i][2]);
         wt_in[i] = 64'(tterm_ff[i][0]) + 64'(tterm_ff[i][1]) + 64'(tterm_ff[i][2]);
      end
   end

   // cm and cm^2 back to engine units
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fprod[i] = 80'(wf_ff[i]) * 80'sd100;
         tprod[i] = 80'(wt_ff[i]) * 80'sd10000;
      end
      rsp_in.force_x  = sat48(fprod[0]);
      rsp_in.force_y  = sat48(fprod[1]);
      rsp_in.force_z  = sat48(fprod[2]);
      rsp_in.torque_x = sat48(tprod[0]);
      rsp_in.torque_y = sat48(tprod[1]);
      rsp_in.torque_z = sat48(tprod[2]);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         flo_ff <= flo_in;
         fhi_ff <= fhi_in;
         tlo_ff <= tlo_in;
         thi_ff <= thi_in;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               fsg_ff[i][j] <= mat_i[i][j][31] ^ f_neg_i[j];
               tsg_ff[i][j] <= mat_i[i][j][31] ^ t_neg_i[j];
            end
         end
      end
      if (adv[1]) begin
         fterm_ff <= fterm_in;
         tterm_ff <= tterm_in;
      end
      if (adv[2]) begin
         wf_ff <= wf_in;
         wt_ff <= wt_in;
      end
      if (adv[3]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_o = rsp_ff;

endmodule

### design/body_frame_quadratic_drag_unit.sv
// 12 register stages lie between item acceptance and rsp_valid.
// Throughput: one item per cycle while the output is not stalled; the widest step is a 32x32 partial product.
// A stalled output holds only the stages behind it; empty stages still fill.
// Reset clears the stage valid bits and the six gain registers to zero.
// ----------------------------------------------------------------------------
// body_frame_quadratic_drag_unit
// Body-frame quadratic drag: world wind and spin in, world force and torque out.
// ----------------------------------------------------------------------------
module body_frame_quadratic_drag_unit
   import bfqd_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  bfqd_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output bfqd_rsp_type rsp_data,
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   bfqd_flow_type      flow_st;
   logic [31:0]        force_gain_ff  [3];
   logic [31:0]        torque_gain_ff [3];
   logic signed [31:0] mat_a  [3][3];
   logic signed [31:0] mat_b  [3][3];
   logic signed [31:0] mat_c  [3][3];
   logic signed [31:0] wind_a [3];
   logic signed [31:0] spin_a [3];
   logic signed [31:0] vel_b  [3];
   logic signed [31:0] rate_b [3];
   logic               f_neg  [3];
   logic [60:0]        f_mag  [3];
   logic               t_neg  [3];
   logic [60:0]        t_mag  [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         force_gain_ff  <= '{default: '0};
         torque_gain_ff <= '{default: '0};
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FORCE_GAIN_X:  force_gain_ff[0]  <= csr_wdata;
            CSR_FORCE_GAIN_Y:  force_gain_ff[1]  <= csr_wdata;
            CSR_FORCE_GAIN_Z:  force_gain_ff[2]  <= csr_wdata;
            CSR_TORQUE_GAIN_X: torque_gain_ff[0] <= csr_wdata;
            CSR_TORQUE_GAIN_Y: torque_gain_ff[1] <= csr_wdata;
            CSR_TORQUE_GAIN_Z: torque_gain_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   bfqd_flow u_flow (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_ready (rsp_ready),
      .flow_o    (flow_st)
   );

   assign req_ready = flow_st.adv[0];
   assign rsp_valid = flow_st.vld[STAGES-1];

   bfqd_front u_front (
      .clock  (clock),
      .adv    (flow_st.adv[2:0]),
      .req    (req_data),
      .mat_o  (mat_a),
      .wind_o (wind_a),
      .spin_o (spin_a)
   );

   bfqd_to_body u_to_body (
      .clock  (clock),
      .adv    (flow_st.adv[4:3]),
      .mat_i  (mat_a),
      .wind_i (wind_a),
      .spin_i (spin_a),
      .mat_o  (mat_b),
      .vel_o  (vel_b),
      .rate_o (rate_b)
   );

   bfqd_drag #(
      .FRAC_BITS (FRAC_BITS)
   ) u_drag (
      .clock   (clock),
      .adv     (flow_st.adv[7:5]),
      .mat_i   (mat_b),
      .vel_i   (vel_b),
      .rate_i  (rate_b),
      .fgain_i (force_gain_ff),
      .tgain_i (torque_gain_ff),
      .mat_o   (mat_c),
      .f_neg_o (f_neg),
      .f_mag_o (f_mag),
      .t_neg_o (t_neg),
      .t_mag_o (t_mag)
   );

   bfqd_to_world u_to_world (
      .clock   (clock),
      .adv     (flow_st.adv[11:8]),
      .mat_i   (mat_c),
      .f_neg_i (f_neg),
      .f_mag_i (f_mag),
      .t_neg_i (t_neg),
      .t_mag_i (t_mag),
      .rsp_o   (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_drain_all: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> (&flow_st.adv))
      else $error("taken result did not advance every stage");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&flow_st.vld))
      else $error("input stalled with an empty stage");

   a_item_count: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !(rsp_valid && rsp_ready)) |=>
      ($countones(flow_st.vld) == $past($countones(flow_st.vld)) + 1))
      else $error("item count in flight off after accept");
`endif

endmodule

### tb/sv/body_frame_quadratic_drag_unit_tb.sv
// ----------------------------------------------------------------------------
// body_frame_quadratic_drag_unit_tb
// Drives wind, spin and rotation items through the drag pipeline, predicts
// world force and torque per item and checks every result in order.
// ----------------------------------------------------------------------------
module body_frame_quadratic_drag_unit_tb
   import bfqd_pkg::*;
;

   localparam int FB = 16;
   localparam longint LIM = 64'sd1152921504606846976;
   localparam longint OMAX = 64'sd140737488355327;
   localparam longint OMIN = -64'sd140737488355328;
   localparam int WATCHDOG = 5000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   bfqd_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   bfqd_rsp_type rsp_data;
   logic         csr_wr_en = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;

   body_frame_quadratic_drag_unit dut (.*);

   always #5 clock = ~clock;

   longint unsigned gain_f [3];
   longint unsigned gain_t [3];

   bfqd_req_type pending_items[$];
   bfqd_rsp_type expected_drag[$];
   int  errors = 0;
   int  idle_cycles = 0;
   bit  hold_sender = 1'b0;
   int  send_wait = 0;
   int  recv_wait = 0;

   // Exact product, truncated toward zero after >> s, magnitude clamped to 2^60.
   function automatic longint mul_shift(longint a, longint b, int s);
      logic [127:0] ma, mb, p;
      logic neg;
      longint r;
      neg = (a < 0) != (b < 0);
      ma = a < 0 ? 128'(-a) : 128'(a);
      mb = b < 0 ? 128'(-b) : 128'(b);
      p = (ma * mb) >> s;
      r = (p > 128'(LIM)) ? LIM : longint'(p);
      return neg ? -r : r;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic bfqd_rsp_type predict_drag(bfqd_req_type it);
      longint qw, qx, qy, qz, xx, yy, zz, xy, xz, yz, wx, wy, wz;
      longint m [3][3];
      longint wv [3], sv [3], lw [3], ls [3], lf [3], lt [3], wf [3], wt [3];
      longint v, w, vsq, wsq;
      bfqd_rsp_type r;
      qw = it.rot_w; qx = it.rot_x; qy = it.rot_y; qz = it.rot_z;
      xx = mul_shift(qx, qx, 30); yy = mul_shift(qy, qy, 30); zz = mul_shift(qz, qz, 30);
      xy = mul_shift(qx, qy, 30); xz = mul_shift(qx, qz, 30); yz = mul_shift(qy, qz, 30);
      wx = mul_shift(qw, qx, 30); wy = mul_shift(qw, qy, 30); wz = mul_shift(qw, qz, 30);
      m[0][0] = 64'sd1073741824 - 2 * (yy + zz);
      m[0][1] = 2 * (xy - wz);
      m[0][2] = 2 * (xz + wy);
      m[1][0] = 2 * (xy + wz);
      m[1][1] = 64'sd1073741824 - 2 * (xx + zz);
      m[1][2] = 2 * (yz - wx);
      m[2][0] = 2 * (xz - wy);
      m[2][1] = 2 * (yz + wx);
      m[2][2] = 64'sd1073741824 - 2 * (xx + yy);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            m[i][j] = clamp(m[i][j], -64'sd2147483648, 64'sd2147483647);
      wv[0] = mul_shift(it.wind_x, 42949673, 32);
      wv[1] = mul_shift(it.wind_y, 42949673, 32);
      wv[2] = mul_shift(it.wind_z, 42949673, 32);
      sv[0] = it.spin_x; sv[1] = it.spin_y; sv[2] = it.spin_z;
      for (int i = 0; i < 3; i++) begin
         lw[i] = 0; ls[i] = 0;
         for (int j = 0; j < 3; j++) begin
            lw[i] += mul_shift(m[j][i], wv[j], 30);
            ls[i] += mul_shift(m[j][i], sv[j], 30);
         end
      end
      for (int i = 0; i < 3; i++) begin
         v = clamp(lw[i], -64'sd2147483648, 64'sd2147483647);
         w = clamp(ls[i], -64'sd2147483648, 64'sd2147483647);
         vsq = mul_shift(v, v < 0 ? -v : v, FB);
         wsq = mul_shift(w, w < 0 ? -w : w, FB);
         lf[i] = mul_shift(vsq, longint'(gain_f[i]), FB);
         lt[i] = -mul_shift(wsq, longint'(gain_t[i]), FB);
      end
      for (int i = 0; i < 3; i++) begin
         wf[i] = 0; wt[i] = 0;
         for (int j = 0; j < 3; j++) begin
            wf[i] += mul_shift(m[i][j], lf[j], 30);
            wt[i] += mul_shift(m[i][j], lt[j], 30);
         end
      end
      r.force_x  = 48'(clamp(mul_shift(wf[0], 100, 0), OMIN, OMAX));
      r.force_y  = 48'(clamp(mul_shift(wf[1], 100, 0), OMIN, OMAX));
      r.force_z  = 48'(clamp(mul_shift(wf[2], 100, 0), OMIN, OMAX));
      r.torque_x = 48'(clamp(mul_shift(wt[0], 10000, 0), OMIN, OMAX));
      r.torque_y = 48'(clamp(mul_shift(wt[1], 10000, 0), OMIN, OMAX));
      r.torque_z = 48'(clamp(mul_shift(wt[2], 10000, 0), OMIN, OMAX));
      return r;
   endfunction

   function automatic logic [31:0] rand_word(int mode);
      case (mode)
         0: return $urandom;
         1: return $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
         2: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
         default: return $urandom_range(0, 32'h03ff_ffff) - 32'h0200_0000;
      endcase
   endfunction

   // Mostly near-unit quaternions from a small set, sometimes raw words.
   function automatic bfqd_req_type rand_item();
      bfqd_req_type it;
      int mode;
      logic signed [31:0] h;
      mode = $urandom_range(0, 3);
      h = 32'sd759250125; // about 0.7071 in Q2.30
      it.wind_x = rand_word(mode); it.wind_y = rand_word(mode); it.wind_z = rand_word(mode);
      mode = $urandom_range(0, 3);
      it.spin_x = rand_word(mode); it.spin_y = rand_word(mode); it.spin_z = rand_word(mode);
      case ($urandom_range(0, 5))
         0: begin it.rot_w = 32'sh4000_0000; it.rot_x = 0; it.rot_y = 0; it.rot_z = 0; end
         1: begin it.rot_w = h; it.rot_x = 0; it.rot_y = 0; it.rot_z = h; end
         2: begin it.rot_w = h; it.rot_x = h; it.rot_y = 0; it.rot_z = 0; end
         3: begin
            it.rot_w = 32'sh2000_0000; it.rot_x = -32'sh2000_0000;
            it.rot_y = 32'sh2000_0000; it.rot_z = 32'sh2000_0000;
         end
         4: begin
            it.rot_w = $urandom_range(0, 32'h7fff_ffff) - 32'h4000_0000;
            it.rot_x = $urandom_range(0, 32'h7fff_ffff) - 32'h4000_0000;
            it.rot_y = $urandom_range(0, 32'h7fff_ffff) - 32'h4000_0000;
            it.rot_z = $urandom_range(0, 32'h7fff_ffff) - 32'h4000_0000;
         end
         default: begin
            it.rot_w = $urandom; it.rot_x = $urandom; it.rot_y = $urandom; it.rot_z = $urandom;
         end
      endcase
      return it;
   endfunction

   function automatic bfqd_req_type make_item(logic [31:0] wv, logic [31:0] sv,
                                              logic [31:0] qw, logic [31:0] qx,
                                              logic [31:0] qy, logic [31:0] qz);
      bfqd_req_type it;
      it.wind_x = wv; it.wind_y = -wv; it.wind_z = wv >>> 1;
      it.spin_x = sv; it.spin_y = ~sv; it.spin_z = sv >>> 2;
      it.rot_w = qw; it.rot_x = qx; it.rot_y = qy; it.rot_z = qz;
      return it;
   endfunction

   // Driver: hold valid until accepted, then draw the next gap.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            send_wait <= $urandom_range(0, 14);
            if (send_wait == 0 && pending_items.size() > 0 && !hold_sender &&
                $urandom_range(0, 14) == 0) begin
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0 && !hold_sender &&
                         $urandom_range(0, 2) == 0) begin
               req_valid <= 1'b1;
               req_data  <= pending_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end else if (!req_valid) begin
            if (send_wait > 0) begin
               send_wait <= send_wait - 1;
            end else if (pending_items.size() > 0 && !hold_sender) begin
               req_valid <= 1'b1;
               req_data  <= pending_items.pop_front();
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         expected_drag.push_back(predict_drag(req_data));
   end

   // Monitor: compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      bfqd_rsp_type e;
      int rw;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_drag.size() == 0) begin
               $error("result with no expectation: %h", rsp_data);
               errors++;
            end else begin
               e = expected_drag.pop_front();
               if (rsp_data.force_x !== e.force_x) begin
                  $error("force_x exp %h got %h", e.force_x, rsp_data.force_x); errors++;
               end
               if (rsp_data.force_y !== e.force_y) begin
                  $error("force_y exp %h got %h", e.force_y, rsp_data.force_y); errors++;
               end
               if (rsp_data.force_z !== e.force_z) begin
                  $error("force_z exp %h got %h", e.force_z, rsp_data.force_z); errors++;
               end
               if (rsp_data.torque_x !== e.torque_x) begin
                  $error("torque_x exp %h got %h", e.torque_x, rsp_data.torque_x); errors++;
               end
               if (rsp_data.torque_y !== e.torque_y) begin
                  $error("torque_y exp %h got %h", e.torque_y, rsp_data.torque_y); errors++;
               end
               if (rsp_data.torque_z !== e.torque_z) begin
                  $error("torque_z exp %h got %h", e.torque_z, rsp_data.torque_z); errors++;
               end
            end
         end
         if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
            rsp_ready <= 1'b0;
         end else if (rsp_valid && rsp_ready) begin
            rw = $urandom_range(0, 14) * ($urandom_range(0, 3) == 0);
            recv_wait <= rw;
            rsp_ready <= (rw == 0);
         end else begin
            rsp_ready <= 1'b1;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic write_gain(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx < CSR_TORQUE_GAIN_X) gain_f[idx] = val;
      else gain_t[idx - CSR_TORQUE_GAIN_X] = val;
   endtask

   // Sample at the falling edge so that no handshake update is half done.
   task automatic drain_pipeline();
      while (!(pending_items.size() == 0 && !req_valid && expected_drag.size() == 0))
         @(negedge clock);
      repeat (STAGES + 4) @(posedge clock);
   endtask

   task automatic set_gains(logic [31:0] f0, logic [31:0] f1, logic [31:0] f2,
                            logic [31:0] t0, logic [31:0] t1, logic [31:0] t2);
      write_gain(CSR_FORCE_GAIN_X, f0);
      write_gain(CSR_FORCE_GAIN_Y, f1);
      write_gain(CSR_FORCE_GAIN_Z, f2);
      write_gain(CSR_TORQUE_GAIN_X, t0);
      write_gain(CSR_TORQUE_GAIN_Y, t1);
      write_gain(CSR_TORQUE_GAIN_Z, t2);
   endtask

   initial begin
      for (int i = 0; i < 3; i++) begin gain_f[i] = 0; gain_t[i] = 0; end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset gains give zero output; check that first.
      pending_items.push_back(make_item(32'h0100_0000, 32'h0001_0000,
                                        32'h4000_0000, 0, 0, 0));
      drain_pipeline();
      set_gains(32'h0001_0000, 32'h0000_8000, 32'h0002_0000,
                32'h0001_0000, 32'h0000_4000, 32'h0000_c000);
      // Extremes, identity, zero and non-unit quaternions, saturation.
      pending_items.push_back(make_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h4000_0000, 0, 0, 0));
      pending_items.push_back(make_item(32'h8000_0000, 32'h8000_0000, 32'h4000_0000, 0, 0, 0));
      pending_items.push_back(make_item(0, 0, 32'h4000_0000, 0, 0, 0));
      pending_items.push_back(make_item(32'h0064_0000, 32'h0001_0000, 0, 0, 0, 0));
      pending_items.push_back(make_item(32'h0064_0000, 32'h0001_0000,
                                        32'h7fff_ffff, 32'h7fff_ffff,
                                        32'h7fff_ffff, 32'h7fff_ffff));
      pending_items.push_back(make_item(32'h0064_0000, 32'hfffe_0000,
                                        32'h8000_0000, 32'h8000_0000,
                                        32'h8000_0000, 32'h8000_0000));
      pending_items.push_back(make_item(32'h0003_0000, 32'h0002_0000,
                                        32'h2d41_3ccd, 0, 0, 32'h2d41_3ccd));
      pending_items.push_back(make_item(32'hffff_ffff, 32'h0000_0001,
                                        0, 32'h4000_0000, 0, 0));
      pending_items.push_back(make_item(32'h1000_0000, 32'h00ff_0000,
                                        0, 0, 32'hc000_0000, 0));
      pending_items.push_back(make_item(32'h0500_0000, 32'h0500_0000,
                                        32'h8000_0000, 32'h7fff_ffff, 0, 32'h8000_0000));
      drain_pipeline();
      set_gains(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      pending_items.push_back(make_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h4000_0000, 0, 0, 0));
      pending_items.push_back(make_item(32'h8000_0000, 32'h8000_0000, 0, 0, 0, 32'h4000_0000));
      pending_items.push_back(make_item(32'h0001_0000, 32'h0000_8000, 32'h4000_0000, 0, 0, 0));
      for (int i = 0; i < 60; i++) pending_items.push_back(rand_item());

      // Random phases with fresh gains (zero in the last), one pause on full drain in between.
      for (int ph = 0; ph < 6; ph++) begin
         drain_pipeline();
         if (ph == 5) set_gains(0, 0, 0, 0, 0, 0);
         else set_gains($urandom_range(0, 32'h0004_0000), $urandom,
                        $urandom_range(0, 32'h0000_ffff), $urandom_range(0, 32'h0004_0000),
                        $urandom, $urandom_range(0, 32'h0000_ffff));
         for (int i = 0; i < 130; i++) begin
            pending_items.push_back(rand_item());
            if (ph == 2 && i == 65) begin
               while (!(pending_items.size() == 0 && !req_valid)) @(negedge clock);
               hold_sender = 1'b1;
               while (expected_drag.size() != 0) @(negedge clock);
               hold_sender = 1'b0;
            end
         end
      end
      drain_pipeline();
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
